// File: hdl/modinv_pkg.sv
// ----------------------------------------------------------------------------
// modinv_pkg
// Shared constants and controller/datapath interface types for the
// extended-gcd / modular inverse block.
// ----------------------------------------------------------------------------
package modinv_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int MAX_ITER_DEF   = 10000;

  // operation codes
  localparam logic OP_EXT_GCD = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  // divider operand selection
  typedef enum logic [1:0] {
    SEL_FIX_A,
    SEL_STEP,
    SEL_FIX_U
  } div_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     apply_fix_a;
    logic     apply_step;
    logic     apply_fix_u;
    logic     publish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fix_a_needed;
    logic fix_u_needed;
    logic rn_zero;
    logic iter_cap;
    logic div_busy;
    logic div_done;
  } status_t;

endpackage

// File: hdl/modinv_div.sv
// ----------------------------------------------------------------------------
// modinv_div
// Bit-serial restoring signed divider, truncating toward zero, with two
// shift-add accumulators that form m0*|q| and m1*|q| as quotient bits appear.
// ----------------------------------------------------------------------------
module modinv_div #(
  parameter int DATA_WIDTH = modinv_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] numer,
  input  logic [DATA_WIDTH-1:0] denom,
  input  logic [DATA_WIDTH-1:0] mul0,
  input  logic [DATA_WIDTH-1:0] mul1,
  output logic                  busy,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] rem_out,
  output logic [DATA_WIDTH-1:0] prod0,
  output logic [DATA_WIDTH-1:0] prod1,
  output logic                  quo_neg
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] dmag;
  logic [DATA_WIDTH-1:0] m0;
  logic [DATA_WIDTH-1:0] m1;
  logic                  num_neg;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] nmag_in;
  logic [DATA_WIDTH-1:0] dmag_in;

  assign nmag_in = numer[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - numer) : numer;
  assign dmag_in = denom[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - denom) : denom;

  // one restoring step per cycle
  assign shifted = {rem, quo[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dmag};
  assign qbit    = ~diff[DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt     <= CW'(DATA_WIDTH);
      quo     <= nmag_in;
      rem     <= '0;
      dmag    <= dmag_in;
      m0      <= mul0;
      m1      <= mul1;
      prod0   <= '0;
      prod1   <= '0;
      num_neg <= numer[DATA_WIDTH-1];
      quo_neg <= numer[DATA_WIDTH-1] ^ denom[DATA_WIDTH-1];
    end else if (busy) begin
      cnt   <= cnt - CW'(1);
      rem   <= qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo   <= {quo[DATA_WIDTH-2:0], qbit};
      prod0 <= {prod0[DATA_WIDTH-2:0], 1'b0} + (qbit ? m0 : '0);
      prod1 <= {prod1[DATA_WIDTH-2:0], 1'b0} + (qbit ? m1 : '0);
    end
  end

  assign rem_out = num_neg ? (DATA_WIDTH'(0) - rem) : rem;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a division in flight");
`endif

endmodule

// File: hdl/modinv_dpath.sv
// ----------------------------------------------------------------------------
// modinv_dpath
// Euclid registers (r, u, v and their successors), modulus, iteration
// count, shared divider and the result register.
// ----------------------------------------------------------------------------
module modinv_dpath #(
  parameter int DATA_WIDTH     = modinv_pkg::DATA_WIDTH_DEF,
  parameter int MAX_ITERATIONS = modinv_pkg::MAX_ITER_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  modinv_pkg::cmd_t             cmd,
  output modinv_pkg::status_t          sts,
  input  logic                         operation,
  input  logic signed [DATA_WIDTH-1:0] value_a,
  input  logic signed [DATA_WIDTH-1:0] value_b,
  output logic signed [DATA_WIDTH-1:0] gcd_value,
  output logic signed [DATA_WIDTH-1:0] coef_u,
  output logic signed [DATA_WIDTH-1:0] coef_v
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);

  logic [DATA_WIDTH-1:0] r;
  logic [DATA_WIDTH-1:0] rn;
  logic [DATA_WIDTH-1:0] u;
  logic [DATA_WIDTH-1:0] un;
  logic [DATA_WIDTH-1:0] v;
  logic [DATA_WIDTH-1:0] vn;
  logic [DATA_WIDTH-1:0] modulus;
  logic                  op;
  logic [IW-1:0]         iter;

  logic [DATA_WIDTH-1:0] div_numer;
  logic [DATA_WIDTH-1:0] div_denom;
  logic [DATA_WIDTH-1:0] div_rem;
  logic [DATA_WIDTH-1:0] prod_u;
  logic [DATA_WIDTH-1:0] prod_v;
  logic                  div_qneg;
  logic                  div_busy;
  logic                  div_done;

  always_comb begin
    case (cmd.div_sel)
      modinv_pkg::SEL_FIX_A: begin
        div_numer = r;
        div_denom = modulus;
      end
      modinv_pkg::SEL_STEP: begin
        div_numer = r;
        div_denom = rn;
      end
      modinv_pkg::SEL_FIX_U: begin
        div_numer = u;
        div_denom = modulus;
      end
      default: begin
        div_numer = r;
        div_denom = rn;
      end
    endcase
  end

  modinv_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .numer  (div_numer),
    .denom  (div_denom),
    .mul0   (un),
    .mul1   (vn),
    .busy   (div_busy),
    .done   (div_done),
    .rem_out(div_rem),
    .prod0  (prod_u),
    .prod1  (prod_v),
    .quo_neg(div_qneg)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r       <= $unsigned(value_a);
      rn      <= $unsigned(value_b);
      modulus <= $unsigned(value_b);
      op      <= operation;
      u       <= DATA_WIDTH'(1);
      un      <= '0;
      v       <= '0;
      vn      <= DATA_WIDTH'(1);
      iter    <= '0;
    end else if (cmd.apply_fix_a) begin
      r <= div_rem + modulus;
    end else if (cmd.apply_step) begin
      // q*m is formed as |q|*m; its sign folds into add or subtract
      r    <= rn;
      rn   <= div_rem;
      u    <= un;
      un   <= div_qneg ? (u + prod_u) : (u - prod_u);
      v    <= vn;
      vn   <= div_qneg ? (v + prod_v) : (v - prod_v);
      iter <= iter + IW'(1);
    end else if (cmd.apply_fix_u) begin
      u <= div_rem + modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      gcd_value <= $signed(r);
      coef_u    <= $signed(u);
      coef_v    <= $signed(v);
    end
  end

  assign sts.fix_a_needed = (op == modinv_pkg::OP_INVERSE) && r[DATA_WIDTH-1];
  assign sts.fix_u_needed = (op == modinv_pkg::OP_INVERSE) && u[DATA_WIDTH-1];
  assign sts.rn_zero      = (rn == '0);
  assign sts.iter_cap     = (iter == IW'(MAX_ITERATIONS));
  assign sts.div_busy     = div_busy;
  assign sts.div_done     = div_done;

endmodule

// File: hdl/modinv_ctrl.sv
// ----------------------------------------------------------------------------
// modinv_ctrl
// Sequencer: operand load, optional mapping of a, Euclid iterations,
// optional mapping of u, and hand-off to the output register.
// ----------------------------------------------------------------------------
module modinv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output modinv_pkg::cmd_t    cmd,
  input  modinv_pkg::status_t sts
);

  typedef enum logic [2:0] {
    IDLE,
    PREP,
    WAIT_FIX_A,
    CHECK,
    WAIT_STEP,
    FINISH,
    WAIT_FIX_U,
    DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = ~out_valid | ~out_stall;
  assign in_stall = (state != IDLE);

  always_comb begin
    cmd        = '0;
    cmd.div_sel = modinv_pkg::SEL_STEP;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = PREP;
        end
      end
      PREP: begin
        if (sts.fix_a_needed) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = modinv_pkg::SEL_FIX_A;
          state_next    = WAIT_FIX_A;
        end else begin
          state_next = CHECK;
        end
      end
      WAIT_FIX_A: begin
        if (sts.div_done) begin
          cmd.apply_fix_a = 1'b1;
          state_next      = CHECK;
        end
      end
      CHECK: begin
        if (sts.rn_zero || sts.iter_cap) begin
          state_next = FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = WAIT_STEP;
        end
      end
      WAIT_STEP: begin
        if (sts.div_done) begin
          cmd.apply_step = 1'b1;
          state_next     = CHECK;
        end
      end
      FINISH: begin
        if (sts.fix_u_needed) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = modinv_pkg::SEL_FIX_U;
          state_next    = WAIT_FIX_U;
        end else begin
          state_next = DONE;
        end
      end
      WAIT_FIX_U: begin
        if (sts.div_done) begin
          cmd.apply_fix_u = 1'b1;
          state_next      = DONE;
        end
      end
      DONE: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || !out_stall))
    else $error("result published over an untaken result");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second operand transfer taken while busy");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("division started while divider busy");
`endif

endmodule

// File: hdl/modular_inverse_ext_euclid.sv
// Each Euclid iteration runs one division, plus one more for each mapping of a
//   negative a or u in inverse mode.
// Throughput: one item at a time; set by the bit-serial divider, one quotient
//   bit per cycle, and by the number of Euclid iterations (at most ~47 at 32 bits).
// Reset: rst is synchronous, active high; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Extended Euclidean gcd with Bezout coefficients, or inverse of a modulo b.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid #(
  parameter int DATA_WIDTH     = modinv_pkg::DATA_WIDTH_DEF,
  parameter int MAX_ITERATIONS = modinv_pkg::MAX_ITER_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // operand channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic signed [DATA_WIDTH-1:0] value_a,
  input  logic signed [DATA_WIDTH-1:0] value_b,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] gcd_value,
  output logic signed [DATA_WIDTH-1:0] coef_u,
  output logic signed [DATA_WIDTH-1:0] coef_v
);

  // commands from the sequencer, status back from the datapath
  modinv_pkg::cmd_t    cmd;
  modinv_pkg::status_t sts;

  // sequencer: accepts one operand transfer, steps the Euclid loop,
  // and owns out_valid of the result register
  modinv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: remainder / coefficient registers, shared divider with
  // shift-add coefficient products, result register
  modinv_dpath #(
    .DATA_WIDTH    (DATA_WIDTH),
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .operation(operation),
    .value_a  (value_a),
    .value_b  (value_b),
    .gcd_value(gcd_value),
    .coef_u   (coef_u),
    .coef_v   (coef_v)
  );

endmodule

// File: tb/modular_inverse_ext_euclid_checker.sv
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_checker
// Watches both channels of the gcd / inverse block. It computes the expected
// gcd and Bezout coefficients for every operand transfer and checks each
// result transfer against the oldest one in order.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_checker #(
  parameter int W        = modinv_pkg::DATA_WIDTH_DEF,
  parameter int STEP_CAP = modinv_pkg::MAX_ITER_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                operation,
  input  logic signed [W-1:0] value_a,
  input  logic signed [W-1:0] value_b,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [W-1:0] gcd_value,
  input  logic signed [W-1:0] coef_u,
  input  logic signed [W-1:0] coef_v,
  output int                  failures,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  typedef logic signed [W-1:0] word_t;

  typedef struct packed {
    word_t gcd;
    word_t u;
    word_t v;
  } bezout_t;

  typedef struct {
    logic    op;
    word_t   a;
    word_t   b;
    bezout_t res;
  } job_t;

  job_t bezout_q[$];

  // quotient rounded toward zero; zero divisor gives all ones
  function automatic word_t trunc_quot(word_t n, word_t d);
    logic [W-1:0] mn, md, q;
    if (d == 0) return '1;
    mn = n[W-1] ? -n : n;
    md = d[W-1] ? -d : d;
    q  = mn / md;
    return (n[W-1] ^ d[W-1]) ? -q : q;
  endfunction

  // remainder with the sign of the dividend; zero divisor gives the dividend
  function automatic word_t trunc_rem(word_t n, word_t d);
    logic [W-1:0] mn, md, r;
    if (d == 0) return n;
    mn = n[W-1] ? -n : n;
    md = d[W-1] ? -d : d;
    r  = mn % md;
    return n[W-1] ? -r : r;
  endfunction

  function automatic word_t lift_negative(word_t x, word_t p);
    return x[W-1] ? trunc_rem(x, p) + p : x;
  endfunction

  function automatic bezout_t ext_euclid(logic op, word_t a, word_t b);
    word_t   r, rn, u, un, v, vn, q, t;
    int      steps;
    bezout_t res;
    if (op == modinv_pkg::OP_INVERSE) a = lift_negative(a, b);
    r = a; rn = b; u = 1; un = 0; v = 0; vn = 1;
    steps = 0;
    while (rn != 0 && steps < STEP_CAP) begin
      q  = trunc_quot(r, rn);
      t  = r - rn * q;  r = rn; rn = t;
      t  = u - un * q;  u = un; un = t;
      t  = v - vn * q;  v = vn; vn = t;
      steps++;
    end
    if (op == modinv_pkg::OP_INVERSE) u = lift_negative(u, b);
    res.gcd = r;
    res.u   = u;
    res.v   = v;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    failures++;
    if (failures <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, word_t got, word_t want, job_t j);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d (op %0d a %0d b %0d)",
                                name, got, want, j.op, j.a, j.b));
  endtask

  always @(posedge clk) begin
    job_t j;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        j.op  = operation;
        j.a   = value_a;
        j.b   = value_b;
        j.res = ext_euclid(operation, value_a, value_b);
        bezout_q.push_back(j);
      end
      if (out_valid && !out_stall) begin
        if (bezout_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result gcd %0d u %0d v %0d",
                                    gcd_value, coef_u, coef_v));
        end else begin
          j = bezout_q.pop_front();
          check_field("gcd_value", gcd_value, j.res.gcd, j);
          check_field("coef_u", coef_u, j.res.u, j);
          check_field("coef_v", coef_v, j.res.v, j);
        end
      end
    end
    pending <= bezout_q.size();
  end

endmodule

// File: tb/modular_inverse_ext_euclid_test.sv
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_test
// Drives directed and random operand pairs in both operations through the
// gcd / inverse block, with bursty input and a stalling result side, and
// leaves all checking to the checker module instantiated beside the block.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W            = modinv_pkg::DATA_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 346;
  // long result-side hold-off, well beyond one worst-case item
  localparam int HOLD_CYCLES  = 4000;
  localparam int HOLD_AFTER   = 40;
  // tail wait after the last result, about one worst-case item
  localparam int TAIL_CYCLES  = 2000;
  // cycles with no transfer on either side before we give up
  localparam int IDLE_LIMIT   = 30000;

  typedef logic signed [W-1:0] word_t;

  localparam word_t WORD_MIN = {1'b1, {(W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(W-1){1'b1}}};

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  logic  operation;
  word_t value_a;
  word_t value_b;
  logic  out_valid;
  logic  out_stall;
  word_t gcd_value;
  word_t coef_u;
  word_t coef_v;

  int failures;
  int pending;
  int results_seen;
  int idle_cycles;
  int burst_left;

  modular_inverse_ext_euclid u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .value_a   (value_a),
    .value_b   (value_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gcd_value (gcd_value),
    .coef_u    (coef_u),
    .coef_v    (coef_v)
  );

  modular_inverse_ext_euclid_checker #(.W(W)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .value_a   (value_a),
    .value_b   (value_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gcd_value (gcd_value),
    .coef_u    (coef_u),
    .coef_v    (coef_v),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result count for the hold-off trigger, plus the no-progress watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) results_seen <= results_seen + 1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: segments of different stall behavior, and one long hold-off
  // once enough results have gone by so the block backs up into its input
  initial begin : result_side
    int  mode;
    int  seg_left;
    int  period;
    int  phase;
    bit  held;
    out_stall <= 1'b0;
    seg_left = 0;
    phase    = 0;
    held     = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 400);
        period   = $urandom_range(2, 7);
      end
      seg_left--;
      phase++;
      case (mode)
        0: out_stall <= 1'b0;                              // always ready
        1: out_stall <= ($urandom_range(0, 9) < 3);       // light stalls
        2: out_stall <= ($urandom_range(0, 9) < 8);       // heavy stalls
        default: out_stall <= (phase % period) != 0;       // fixed duty pattern
      endcase
    end
  end

  // one operand transfer; valid stays up across a burst, drops for a gap after
  task automatic offer(input logic op, input word_t a, input word_t b);
    int gap;
    in_valid  <= 1'b1;
    operation <= op;
    value_a   <= a;
    value_b   <= b;
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) begin
      // mostly short gaps, some that land mid-computation, a few very long
      case ($urandom_range(0, 19))
        0:               gap = $urandom_range(200, 1500);
        1, 2, 3, 4, 5:   gap = $urandom_range(9, 200);
        default:         gap = $urandom_range(1, 8);
      endcase
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 25);
    end else begin
      burst_left--;
    end
  endtask

  // operand mix: full-width random, small values, edge values, 16-bit range
  function automatic word_t pick_operand();
    word_t x;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: x = $urandom;
      4, 5:       x = $signed($urandom_range(0, 2000)) - 1000;
      6: begin
        case ($urandom_range(0, 4))
          0:       x = WORD_MIN;
          1:       x = WORD_MAX;
          2:       x = 0;
          3:       x = 1;
          default: x = -1;
        endcase
      end
      default: begin
        x = $urandom;
        x = x >>> 16;
      end
    endcase
    return x;
  endfunction

  // positive moduli for inverse mode, primes among them so inverses exist
  function automatic word_t pick_modulus();
    word_t p;
    case ($urandom_range(0, 5))
      0, 1: p = $urandom_range(2, 1000);
      2, 3: p = $urandom >> 1;
      default: begin
        case ($urandom_range(0, 3))
          0:       p = WORD_MAX;
          1:       p = 65521;
          2:       p = 65537;
          default: p = 1000000007;
        endcase
      end
    endcase
    return p;
  endfunction

  initial begin : stimulus
    logic  op;
    word_t a;
    word_t b;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    operation <= modinv_pkg::OP_EXT_GCD;
    value_a   <= '0;
    value_b   <= '0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // extended gcd: zero second operand, both zero, quotient overflow, extremes
    offer(modinv_pkg::OP_EXT_GCD, 0, 0);
    offer(modinv_pkg::OP_EXT_GCD, 5, 0);
    offer(modinv_pkg::OP_EXT_GCD, WORD_MIN, 0);
    offer(modinv_pkg::OP_EXT_GCD, 0, 7);
    offer(modinv_pkg::OP_EXT_GCD, WORD_MIN, -1);
    offer(modinv_pkg::OP_EXT_GCD, -1, WORD_MIN);
    offer(modinv_pkg::OP_EXT_GCD, WORD_MAX, WORD_MIN);
    offer(modinv_pkg::OP_EXT_GCD, WORD_MIN, WORD_MIN);
    offer(modinv_pkg::OP_EXT_GCD, WORD_MAX, WORD_MAX);
    offer(modinv_pkg::OP_EXT_GCD, 240, 46);
    offer(modinv_pkg::OP_EXT_GCD, -240, 46);
    offer(modinv_pkg::OP_EXT_GCD, 240, -46);
    offer(modinv_pkg::OP_EXT_GCD, 1, 1);
    // fibonacci neighbors give the longest chain of steps
    offer(modinv_pkg::OP_EXT_GCD, 1836311903, 1134903170);

    // inverse: plain, negative a, gcd not one, zero and negative modulus
    offer(modinv_pkg::OP_INVERSE, 3, 11);
    offer(modinv_pkg::OP_INVERSE, -3, 11);
    offer(modinv_pkg::OP_INVERSE, 6, 9);
    offer(modinv_pkg::OP_INVERSE, -5, 0);
    offer(modinv_pkg::OP_INVERSE, 5, 0);
    offer(modinv_pkg::OP_INVERSE, 7, -11);
    offer(modinv_pkg::OP_INVERSE, -7, -11);
    offer(modinv_pkg::OP_INVERSE, WORD_MIN, WORD_MAX);
    offer(modinv_pkg::OP_INVERSE, 0, 13);
    offer(modinv_pkg::OP_INVERSE, -1, WORD_MAX);

    repeat (RANDOM_ITEMS) begin
      op = 1'($urandom_range(0, 1));
      a  = pick_operand();
      b  = pick_operand();
      if (op == modinv_pkg::OP_INVERSE && $urandom_range(0, 3) != 0) b = pick_modulus();
      offer(op, a, b);
    end
    in_valid <= 1'b0;

    // drain every expected result, then watch for stray ones
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/modinv_pkg.sv
hdl/modinv_div.sv
hdl/modinv_dpath.sv
hdl/modinv_ctrl.sv
hdl/modular_inverse_ext_euclid.sv
tb/modular_inverse_ext_euclid_checker.sv
tb/modular_inverse_ext_euclid_test.sv
